[rtl/core/itoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, microcode types and the control store for the signed
// integer to decimal text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    localparam int PC_W = 3;

    localparam logic [PC_W-1:0] PC_LOAD   = 3'd0;
    localparam logic [PC_W-1:0] PC_SIGN   = 3'd1;
    localparam logic [PC_W-1:0] PC_DABBLE = 3'd2;
    localparam logic [PC_W-1:0] PC_SKIP   = 3'd3;
    localparam logic [PC_W-1:0] PC_EMIT   = 3'd4;

    typedef enum logic [2:0] {
        UOP_LOAD,
        UOP_SIGN,
        UOP_DABBLE,
        UOP_SKIP,
        UOP_EMIT
    } t_uop;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_BITS_LEFT,
        COND_LEAD_ZERO,
        COND_MORE_DIGITS
    } t_cond;

    typedef struct packed {
        t_uop            op;
        t_cond           cond;
        logic [PC_W-1:0] jump_pc;
        logic [PC_W-1:0] next_pc;
    } t_ucode;

    // Control store: take on a true condition, else fall to next_pc.
    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode w;
        case (pc)
            PC_LOAD:   w = '{op: UOP_LOAD,   cond: COND_ALWAYS,
                             jump_pc: PC_SIGN,   next_pc: PC_SIGN};
            PC_SIGN:   w = '{op: UOP_SIGN,   cond: COND_ALWAYS,
                             jump_pc: PC_DABBLE, next_pc: PC_DABBLE};
            PC_DABBLE: w = '{op: UOP_DABBLE, cond: COND_BITS_LEFT,
                             jump_pc: PC_DABBLE, next_pc: PC_SKIP};
            PC_SKIP:   w = '{op: UOP_SKIP,   cond: COND_LEAD_ZERO,
                             jump_pc: PC_SKIP,   next_pc: PC_EMIT};
            PC_EMIT:   w = '{op: UOP_EMIT,   cond: COND_MORE_DIGITS,
                             jump_pc: PC_EMIT,   next_pc: PC_LOAD};
            default:   w = '{op: UOP_LOAD,   cond: COND_ALWAYS,
                             jump_pc: PC_LOAD,   next_pc: PC_LOAD};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/itoa_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_in_if
// Input channel: one signed integer word per handshake.
// ----------------------------------------------------------------------------
interface itoa_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[rtl/core/itoa_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_out_if
// Output channel: one ASCII character word per handshake, last marks the end.
// ----------------------------------------------------------------------------
interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

[rtl/core/signed_int_to_decimal_ascii_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed integer to its decimal ASCII text, one character a word.
// ----------------------------------------------------------------------------
// Usage:
//   i_num carries one signed VALUE_BITS-bit integer per word. o_chr returns
//   its text most significant character first: '-' for a negative value,
//   then the digits without leading zeros, last set on the final digit.
//   Zero gives the single character '0'.
// Steps:
//   A word is taken only while the sequencer sits at its load step. After
//   that come one step for the sign, one step per input bit of the
//   bit-serial shift-and-add-3 loop, one step per leading zero dropped plus
//   one, then one step per digit sent. The next word is not taken until the
//   last digit of the current one has gone to the output register. The '-'
//   is registered at the sign step for a negative value, the first digit at
//   the first emit step, after the loop and the leading zeros dropped.
// Reset and stall:
//   Reset returns the step counter to the load step, drops o_chr.valid and
//   holds i_num.ready low. A stalled output holds its word; the sequencer
//   waits on the sign step of a negative value and on the digit steps until the output register frees up.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    itoa_in_if.sink           i_num,
    itoa_out_if.source        o_chr
);

    localparam int NUM_DIGITS = ((VALUE_BITS * 77) >> 8) + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int BITS_W     = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    logic [PC_W-1:0]       r_pc,        n_pc;
    logic                  r_neg,       n_neg;
    logic [VALUE_BITS-1:0] r_mag,       n_mag;
    logic [BCD_W-1:0]      r_bcd,       n_bcd;
    logic [BITS_W-1:0]     r_bits,      n_bits;
    logic [LEFT_W-1:0]     r_left,      n_left;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_char,      n_char;
    logic                  r_last,      n_last;

    t_ucode                w_uc;
    logic                  w_cond;
    logic                  w_stall;
    logic                  w_out_free;
    logic [3:0]            w_top;
    logic [BCD_W-1:0]      w_adj;
    logic [VALUE_BITS-1:0] w_raw;

    assign w_uc       = ucode_rom(r_pc);
    assign w_out_free = !r_out_valid || o_chr.ready;
    assign w_top      = r_bcd[BCD_W-1 -: 4];
    assign w_raw      = VALUE_BITS'(i_num.value);

    // Sequencer: condition and stall for the current control word
    always_comb begin
        case (w_uc.cond)
            COND_ALWAYS:      w_cond = 1'b1;
            COND_BITS_LEFT:   w_cond = (r_bits != BITS_W'(1));
            COND_LEAD_ZERO:   w_cond = (w_top == 4'd0) && (r_left > LEFT_W'(1));
            COND_MORE_DIGITS: w_cond = (r_left != LEFT_W'(1));
            default:          w_cond = 1'b0;
        endcase
    end

    always_comb begin
        case (w_uc.op)
            UOP_LOAD: w_stall = !i_num.valid;
            UOP_SIGN: w_stall = r_neg && !w_out_free;
            UOP_EMIT: w_stall = !w_out_free;
            default:  w_stall = 1'b0;
        endcase
    end

    always_comb begin
        if (w_stall) begin
            n_pc = r_pc;
        end else if (w_cond) begin
            n_pc = w_uc.jump_pc;
        end else begin
            n_pc = w_uc.next_pc;
        end
    end

    assign i_num.ready = i_rst_n && (w_uc.op == UOP_LOAD);

    // Add-3 correction on every BCD digit ahead of the shift
    always_comb begin
        logic [3:0] dig;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            dig = r_bcd[d*4 +: 4];
            w_adj[d*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    // Datapath driven by the control word
    always_comb begin
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_bits      = r_bits;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_chr.ready;
        n_char      = r_char;
        n_last      = r_last;

        case (w_uc.op)
            UOP_LOAD: begin
                if (i_num.valid) begin
                    n_neg  = w_raw[VALUE_BITS-1];
                    n_mag  = w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;
                    n_bcd  = '0;
                    n_bits = BITS_W'(VALUE_BITS);
                    n_left = LEFT_W'(NUM_DIGITS);
                end
            end
            UOP_SIGN: begin
                if (r_neg && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_MINUS;
                    n_last      = 1'b0;
                end
            end
            UOP_DABBLE: begin
                n_bcd  = {w_adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
                n_mag  = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bits = r_bits - BITS_W'(1);
            end
            UOP_SKIP: begin
                // drop a leading zero, keep at least one digit
                if (w_cond) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left = r_left - LEFT_W'(1);
                end
            end
            UOP_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_ZERO + 8'(w_top);
                    n_last      = (r_left == LEFT_W'(1));
                    n_bcd       = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left      = r_left - LEFT_W'(1);
                end
            end
            default: begin
                n_out_valid = r_out_valid && !o_chr.ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_bits <= n_bits;
        r_left <= n_left;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_chr.valid     = r_out_valid;
    assign o_chr.character = r_char;
    assign o_chr.last      = r_last;

    // Assertions
    a_dabble_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_DABBLE) |-> (r_bits != '0))
        else $error("conversion loop entered with no bits left");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_EMIT) |-> (r_left != '0))
        else $error("digit emit with no digits left");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_chr.valid && o_chr.character != ASCII_MINUS) |->
        (o_chr.character >= ASCII_ZERO && o_chr.character <= ASCII_ZERO + 8'd9))
        else $error("non-digit character on output");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_chr.valid && o_chr.character == ASCII_MINUS) |-> !o_chr.last)
        else $error("sign marked as final character");

endmodule
